[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Default screen geometry
  localparam int TCW_COLS = 80;
  localparam int TCW_ROWS = 25;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 11;
  localparam int CURSOR_W   = 11;
  localparam int CELL_W     = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Register select (paddr bit 2)
  localparam logic REG_ATTR = 1'b0;
  localparam logic REG_UTF8 = 1'b1;

  // Characters and reset values
  localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QMARK   = 8'h3F;
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

  // UTF-8 lead byte masks and patterns
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] byte_in;
    logic [IDX_W-1:0]  cell_index;
  } tcw_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] attribute;
    logic              utf8_mode;
  } tcw_cfg_t;

  typedef struct packed {
    logic                valid;
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_data;
  } tcw_res_t;

endpackage

`default_nettype wire

[rtl/text_console_writer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Beat contents
// -------   ---------  ---------------------------------------------------
// s_axis    in         tuser = cmd; tdata = byte_in, cell_index
// m_axis    out        tdata = cursor_pos, cell_data (one beat per input beat)
// apb       in/out     0x0: attribute[7:0], 0x4: utf8_mode[0]
//
// A put runs through the EXEC and DONE states, a read through EXEC, READ and
// DONE; the next beat is taken only once DONE has handed its result on.
// A put that runs off the bottom row scrolls through the sequencer's address
// adder, copying (ROWS-1)*COLS cells and then blanking COLS.
// A clear blanks all COLS*ROWS cells, one cell written per cycle.
// After reset every cell of the store is swept to 0x0F20; no input
// beat is taken meanwhile, register writes are.
// A finished result waits in the output register; the next input beat is
// taken while it stalls, and that beat's result holds until the register
// frees.
module text_console_writer_unit #(
  parameter int COLS = tcw_pkg::TCW_COLS,
  parameter int ROWS = tcw_pkg::TCW_ROWS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] byte_in, [18:8] cell_index, [23:19] zero
  input  logic [tcw_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // [1:0] cmd
  input  logic [tcw_pkg::CMD_W-1:0]         s_axis_tuser_i,
  // Result stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [10:0] cursor_pos, [26:11] cell_data, [31:27] zero
  output logic [tcw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // Register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]        paddr,
  input  logic [tcw_pkg::APB_DW-1:0]        pwdata,
  output logic [tcw_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  import tcw_pkg::*;

  localparam int AW = $clog2(COLS * ROWS);

  logic [BYTE_W-1:0]   attr_q;
  logic                utf8_q;
  logic                cfg_wr;

  tcw_item_t           item;
  tcw_cfg_t            cfg;
  tcw_res_t            res;
  logic                res_ready;

  logic                m_valid_q;
  logic [CURSOR_W-1:0] out_pos_q;
  logic [CELL_W-1:0]   out_data_q;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  // Register port: bit 2 of the address selects the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
      utf8_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ATTR) begin
        attr_q <= pwdata[BYTE_W-1:0];
      end else begin
        utf8_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_UTF8) begin
      prdata = APB_DW'(utf8_q);
    end else begin
      prdata = APB_DW'(attr_q);
    end
  end

  assign cfg.attribute = attr_q;
  assign cfg.utf8_mode = utf8_q;

  // Unpack the input beat
  assign item.cmd        = s_axis_tuser_i;
  assign item.byte_in    = s_axis_tdata_i[BYTE_W-1:0];
  assign item.cell_index = s_axis_tdata_i[BYTE_W +: IDX_W];

  // Output register frees when empty or when the sink takes the beat
  assign res_ready = !m_valid_q || m_axis_tready_i;

  tcw_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid_i),
    .item_ready_o (s_axis_tready_o),
    .item_i       (item),
    .cfg_i        (cfg),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  // Screen store: one cell per word
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (COLS * ROWS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold the result beat until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res.valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_pos_q  <= res.cursor_pos;
      out_data_q <= res.cell_data;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_data_q, out_pos_q});

endmodule

`default_nettype wire

[rtl/tcw_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/tcw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl #(
  parameter int COLS = tcw_pkg::TCW_COLS,
  parameter int ROWS = tcw_pkg::TCW_ROWS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  output logic                              item_ready_o,
  input  tcw_pkg::tcw_item_t                item_i,
  input  tcw_pkg::tcw_cfg_t                 cfg_i,
  input  logic                              res_ready_i,
  output tcw_pkg::tcw_res_t                 res_o,
  output logic                              ram_we_o,
  output logic [$clog2(COLS*ROWS)-1:0]      ram_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]        ram_wdata_o,
  output logic                              ram_re_o,
  output logic [$clog2(COLS*ROWS)-1:0]      ram_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]        ram_rdata_i
);

  import tcw_pkg::*;

  localparam int CELLS  = COLS * ROWS;
  localparam int N_COPY = (ROWS - 1) * COLS;
  localparam int AW     = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLS);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_SCROLL = 7'b0001000,
    ST_BLANK  = 7'b0010000,
    ST_READ   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  tcw_item_t         item_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [AW-1:0]     row_base_q, row_base_d;
  logic [1:0]        skip_q, skip_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [AW-1:0]     last_q, last_d;
  logic              drain_q, drain_d;
  logic              wv_q, wv_d;
  logic [AW-1:0]     wa_q, wa_d;
  logic [CELL_W-1:0] data_q, data_d;

  // Shared address adder
  logic [AW-1:0]     add_a, add_b, add_sum;

  logic              hi_byte;
  logic [BYTE_W-1:0] eff_b;
  logic [CELL_W-1:0] blank;
  logic              last_row;
  logic              adv;

  assign add_sum  = add_a + add_b;
  assign hi_byte  = cfg_i.utf8_mode && item_q.byte_in[BYTE_W-1];
  assign eff_b    = hi_byte ? CH_QMARK : item_q.byte_in;
  assign blank    = {cfg_i.attribute, CH_SPACE};
  assign last_row = (row_base_q == AW'(N_COPY));

  // Operands of the shared address adder
  always_comb begin
    add_a = row_base_q;
    add_b = AW'(col_q);
    if (state_q == ST_SCROLL) begin
      add_a = cnt_q;
      add_b = AW'(COLS);
    end else if (state_q == ST_EXEC && item_q.cmd == CMD_PUT && eff_b == CH_BS &&
                 col_q != '0) begin
      // Backspace blanks the cell left of the cursor
      add_b = AW'(col_q - COL_W'(1));
    end
  end

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_base_d = row_base_q;
    skip_d     = skip_q;
    cnt_d      = cnt_q;
    last_d     = last_q;
    drain_d    = drain_q;
    wv_d       = wv_q;
    wa_d       = wa_q;
    data_d     = data_q;
    adv        = 1'b0;

    ram_we_o    = 1'b0;
    ram_waddr_o = add_sum;
    ram_wdata_o = blank;
    ram_re_o    = 1'b0;
    ram_raddr_o = AW'(item_q.cell_index);

    item_ready_o      = (state_q == ST_IDLE);
    res_o.valid       = 1'b0;
    res_o.cursor_pos  = CURSOR_W'(add_sum);
    res_o.cell_data   = data_q;

    case (state_q)
      ST_INIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q;
        ram_wdata_o = RESET_CELL;
        if (cnt_q == last_q) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        data_d  = '0;
        state_d = ST_DONE;
        case (item_q.cmd)
          CMD_PUT: begin
            if (skip_q != 2'd0) begin
              skip_d = skip_q - 2'd1;
            end else begin
              if (hi_byte) begin
                if ((item_q.byte_in & LEAD2_MASK) == LEAD2_PAT) begin
                  skip_d = 2'd1;
                end else if ((item_q.byte_in & LEAD3_MASK) == LEAD3_PAT) begin
                  skip_d = 2'd2;
                end else if ((item_q.byte_in & LEAD4_MASK) == LEAD4_PAT) begin
                  skip_d = 2'd3;
                end
              end
              if (eff_b == CH_NL) begin
                col_d = '0;
                adv   = 1'b1;
              end else if (eff_b == CH_BS) begin
                // Step back and blank, never past column 0
                if (col_q != '0) begin
                  ram_we_o    = 1'b1;
                  ram_wdata_o = blank;
                  col_d       = col_q - COL_W'(1);
                end
              end else begin
                ram_we_o    = 1'b1;
                ram_wdata_o = {cfg_i.attribute, eff_b};
                if (col_q == COL_W'(COLS - 1)) begin
                  col_d = '0;
                  adv   = 1'b1;
                end else begin
                  col_d = col_q + COL_W'(1);
                end
              end
              if (adv) begin
                if (last_row) begin
                  state_d = ST_SCROLL;
                  cnt_d   = '0;
                  drain_d = 1'b0;
                  wv_d    = 1'b0;
                end else begin
                  row_base_d = row_base_q + AW'(COLS);
                end
              end
            end
          end
          CMD_CLEAR: begin
            col_d      = '0;
            row_base_d = '0;
            skip_d     = 2'd0;
            cnt_d      = '0;
            last_d     = AW'(CELLS - 1);
            state_d    = ST_BLANK;
          end
          CMD_READ: begin
            if (32'(item_q.cell_index) < CELLS) begin
              ram_re_o = 1'b1;
              state_d  = ST_READ;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCROLL: begin
        // Read one row ahead, write back the word read last cycle
        ram_re_o    = !drain_q;
        ram_raddr_o = add_sum;
        ram_we_o    = wv_q;
        ram_waddr_o = wa_q;
        ram_wdata_o = ram_rdata_i;
        wa_d        = cnt_q;
        wv_d        = !drain_q;
        if (drain_q) begin
          state_d = ST_BLANK;
          cnt_d   = AW'(N_COPY);
          last_d  = AW'(CELLS - 1);
        end else if (cnt_q == AW'(N_COPY - 1)) begin
          drain_d = 1'b1;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_BLANK: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cnt_q;
        ram_wdata_o = blank;
        if (cnt_q == last_q) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_READ: begin
        data_d  = ram_rdata_i;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        res_o.valid = res_ready_i;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      col_q      <= '0;
      row_base_q <= '0;
      skip_q     <= 2'd0;
      cnt_q      <= '0;
      last_q     <= AW'(CELLS - 1);
      drain_q    <= 1'b0;
      wv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      col_q      <= col_d;
      row_base_q <= row_base_d;
      skip_q     <= skip_d;
      cnt_q      <= cnt_d;
      last_q     <= last_d;
      drain_q    <= drain_d;
      wv_q       <= wv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    data_q <= data_d;
    if (item_ready_o && item_valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire
